/* hdl/fise_pkg.sv */
package fise_pkg;

    localparam int TICK_W  = 10;
    localparam int SCALE_W = 18;
    localparam int RATE_W  = 24;
    localparam int NS_W    = 30;
    localparam int DUR_W   = 29;
    localparam int TIME_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = TIME_W + SCALE_W;

    localparam logic [NS_W-1:0] NS_PER_SECOND = 30'd1_000_000_000;

    localparam logic [TIME_W-1:0] ONE_BYTE_LIMIT   = 32'h0000_0080;
    localparam logic [TIME_W-1:0] TWO_BYTE_LIMIT   = 32'h0000_4000;
    localparam logic [TIME_W-1:0] THREE_BYTE_LIMIT = 32'h0020_0000;
    localparam logic [TIME_W-1:0] FOUR_BYTE_LIMIT  = 32'h1000_0000;

    localparam logic [7:0] PREFIX_TWO     = 8'h80;
    localparam logic [7:0] PREFIX_THREE   = 8'hC0;
    localparam logic [7:0] PREFIX_FOUR    = 8'hE0;
    localparam logic [7:0] SATURATED_HEAD = 8'hE0 | 8'h0F;
    localparam logic [7:0] FILL_BYTE      = 8'hFF;
    localparam logic [7:0] WEAK_BYTE      = 8'h01;

    localparam logic [TICK_W-1:0]  TICK_PERIOD_RESET = 10'd40;
    localparam logic [SCALE_W-1:0] SPEED_SCALE_RESET = 18'd65536;

    // register index, taken from paddr[2]
    localparam logic REG_TICK_PERIOD = 1'b0;
    localparam logic REG_SPEED_SCALE = 1'b1;

    typedef struct packed {
        logic              track_start;
        logic              data_bit;
        logic              weak_bit;
        logic [RATE_W-1:0] cell_bitrate;
    } t_in_item;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } t_out_item;

    // classified cell as it passes from front to back
    typedef struct packed {
        logic             track_start;
        logic             pulse;
        logic             weak_bit;
        logic [DUR_W-1:0] duration_ns;
    } t_cell;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_ENC,
        B_EMIT
    } t_back_state;

endpackage

/* hdl/flux_interval_stream_encoder.sv */
// Flux interval stream encoder: one floppy bit cell in per beat, 1 to 5 stream bytes out per
// cell that carries a flux transition or weak bit (none for a quiet cell), with last_byte set
// on the final byte of each cell. The front computes each cell's duration with a 30-step
// divider and takes no new cell until it has pushed the last one; a queue of QUEUE_DEPTH
// cells decouples it from the back, which divides the elapsed time by the tick period in
// 32 steps, scales it, and sends the bytes one per cycle while the output is not stalled.
// Registers: 0x0 tick_period_ns (10 bits, 0 acts as 1), 0x4 speed_scale_q16 (18 bits, Q16);
// write them only while the block is idle.
module flux_interval_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fise_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fise_pkg::t_out_item o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [fise_pkg::TICK_W-1:0]  r_tick_period;
    logic [fise_pkg::SCALE_W-1:0] r_speed_scale;

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;
    fise_pkg::t_cell q_in;
    fise_pkg::t_cell q_out;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= fise_pkg::TICK_PERIOD_RESET;
            r_speed_scale <= fise_pkg::SPEED_SCALE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                fise_pkg::REG_TICK_PERIOD: r_tick_period <= pwdata[fise_pkg::TICK_W-1:0];
                fise_pkg::REG_SPEED_SCALE: r_speed_scale <= pwdata[fise_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            fise_pkg::REG_TICK_PERIOD: prdata = 32'(r_tick_period);
            fise_pkg::REG_SPEED_SCALE: prdata = 32'(r_speed_scale);
            default:                   prdata = '0;
        endcase
    end

    fise_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .o_push  (q_push),
        .o_cell  (q_in),
        .i_full  (q_full)
    );

    fise_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    fise_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cell        (q_out),
        .o_pop         (q_pop),
        .i_tick_period (r_tick_period),
        .i_speed_scale (r_speed_scale),
        .o_out_valid   (o_out_valid),
        .o_out_item    (o_out_item),
        .i_out_stall   (i_out_stall)
    );

endmodule

/* hdl/fise_div.sv */
module fise_div #(
    parameter int DVD_W = 32,
    parameter int DVR_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVR_W-1:0] r_rem;
    logic [DVR_W-1:0] r_dvr;
    logic [DVD_W-1:0] r_quo;

    logic [DVR_W:0]   trial;
    logic             ge;
    logic [DVR_W:0]   diff;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        ge    = trial >= {1'b0, r_dvr};
        diff  = trial - {1'b0, r_dvr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(DVD_W);
            r_rem <= '0;
            r_dvr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_rem <= ge ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hdl/fise_queue.sv */
module fise_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fise_pkg::t_cell i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output fise_pkg::t_cell o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fise_pkg::t_cell  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* hdl/fise_front.sv */
module fise_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  fise_pkg::t_in_item i_item,
    output logic               o_push,
    output fise_pkg::t_cell    o_cell,
    input  logic               i_full
);

    fise_pkg::t_front_state r_state;
    fise_pkg::t_front_state n_state;
    fise_pkg::t_cell        r_cell;

    logic                          accept;
    logic                          div_start;
    logic                          div_done;
    logic [fise_pkg::NS_W-1:0]     div_quo;
    logic [fise_pkg::RATE_W:0]     divisor;

    // cell time is 1e9 / (2 * bitrate)
    assign divisor = {i_item.cell_bitrate, 1'b0};
    assign accept  = i_valid && !o_stall;

    fise_div #(
        .DVD_W (fise_pkg::NS_W),
        .DVR_W (fise_pkg::RATE_W + 1)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (fise_pkg::NS_PER_SECOND),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state   = r_state;
        o_stall   = 1'b1;
        o_push    = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            fise_pkg::F_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_item.cell_bitrate == '0) begin
                        n_state = fise_pkg::F_PUSH;
                    end else begin
                        div_start = 1'b1;
                        n_state   = fise_pkg::F_DIV;
                    end
                end
            end
            fise_pkg::F_DIV: begin
                if (div_done) begin
                    n_state = fise_pkg::F_PUSH;
                end
            end
            fise_pkg::F_PUSH: begin
                o_push = 1'b1;
                if (!i_full) begin
                    n_state = fise_pkg::F_IDLE;
                end
            end
            default: n_state = fise_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fise_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cell.track_start <= i_item.track_start;
            r_cell.pulse       <= i_item.data_bit || i_item.weak_bit;
            r_cell.weak_bit    <= i_item.weak_bit;
            r_cell.duration_ns <= '0;
        end else if (div_done) begin
            r_cell.duration_ns <= div_quo[fise_pkg::DUR_W-1:0];
        end
    end

    assign o_cell = r_cell;

endmodule

/* hdl/fise_back.sv */
module fise_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  fise_pkg::t_cell              i_cell,
    output logic                         o_pop,
    input  logic [fise_pkg::TICK_W-1:0]  i_tick_period,
    input  logic [fise_pkg::SCALE_W-1:0] i_speed_scale,
    output logic                         o_out_valid,
    output fise_pkg::t_out_item          o_out_item,
    input  logic                         i_out_stall
);

    localparam int TW = fise_pkg::TIME_W;

    fise_pkg::t_back_state r_state;
    fise_pkg::t_back_state n_state;

    logic [TW-1:0]              r_elapsed;
    logic [TW-1:0]              r_last;
    logic                       r_weak;
    logic [fise_pkg::DUR_W-1:0] r_dur;
    logic [TW-1:0]              r_pos;
    logic [39:0]                r_sh;
    logic [2:0]                 r_cnt;
    logic                       r_out_valid;
    fise_pkg::t_out_item        r_out;

    logic                          out_free;
    logic                          out_load;
    logic                          div_start;
    logic                          div_done;
    logic [TW-1:0]                 div_quo;
    logic [fise_pkg::TICK_W-1:0]   period;
    logic [TW-1:0]                 base_elapsed;
    logic [TW-1:0]                 base_last;
    logic [TW-1:0]                 dur_ext;
    logic [fise_pkg::PROD_W-1:0]   prod;
    logic [TW-1:0]                 delta;
    logic [31:0]                   code;
    logic [2:0]                    code_len;
    logic [39:0]                   seq;

    assign period       = (i_tick_period == '0) ? fise_pkg::TICK_W'(1) : i_tick_period;
    assign base_elapsed = i_cell.track_start ? '0 : r_elapsed;
    assign base_last    = i_cell.track_start ? '0 : r_last;
    assign dur_ext      = TW'(i_cell.duration_ns);
    assign out_free     = !r_out_valid || !i_out_stall;

    fise_div #(
        .DVD_W (TW),
        .DVR_W (fise_pkg::TICK_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (base_elapsed),
        .i_divisor  (period),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign prod = {{fise_pkg::SCALE_W{1'b0}}, div_quo}
                * {{TW{1'b0}}, i_speed_scale};

    // prefix code of the delta, left aligned
    always_comb begin
        delta = r_pos - r_last;
        if (delta < fise_pkg::ONE_BYTE_LIMIT) begin
            code     = {delta[7:0], 24'd0};
            code_len = 3'd1;
        end else if (delta < fise_pkg::TWO_BYTE_LIMIT) begin
            code     = {fise_pkg::PREFIX_TWO | {2'b00, delta[13:8]}, delta[7:0], 16'd0};
            code_len = 3'd2;
        end else if (delta < fise_pkg::THREE_BYTE_LIMIT) begin
            code     = {fise_pkg::PREFIX_THREE | {3'b000, delta[20:16]},
                        delta[15:8], delta[7:0], 8'd0};
            code_len = 3'd3;
        end else if (delta < fise_pkg::FOUR_BYTE_LIMIT) begin
            code     = {fise_pkg::PREFIX_FOUR | {4'b0000, delta[27:24]},
                        delta[23:16], delta[15:8], delta[7:0]};
            code_len = 3'd4;
        end else begin
            code     = {fise_pkg::SATURATED_HEAD, fise_pkg::FILL_BYTE,
                        fise_pkg::FILL_BYTE, fise_pkg::FILL_BYTE};
            code_len = 3'd4;
        end
        seq = {code, 8'd0};
        if (r_weak) begin
            case (code_len)
                3'd1:    seq[31:24] = fise_pkg::WEAK_BYTE;
                3'd2:    seq[23:16] = fise_pkg::WEAK_BYTE;
                3'd3:    seq[15:8]  = fise_pkg::WEAK_BYTE;
                default: seq[7:0]   = fise_pkg::WEAK_BYTE;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            fise_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    if (i_cell.pulse) begin
                        div_start = 1'b1;
                        n_state   = fise_pkg::B_DIV;
                    end
                end
            end
            fise_pkg::B_DIV: begin
                if (div_done) begin
                    n_state = fise_pkg::B_ENC;
                end
            end
            fise_pkg::B_ENC: begin
                n_state = fise_pkg::B_EMIT;
            end
            fise_pkg::B_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_cnt == 3'd1) begin
                        n_state = fise_pkg::B_IDLE;
                    end
                end
            end
            default: n_state = fise_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fise_pkg::B_IDLE;
            r_out_valid <= 1'b0;
            r_elapsed   <= '0;
            r_last      <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_last    <= base_last;
                r_elapsed <= i_cell.pulse ? base_elapsed : base_elapsed + dur_ext;
            end else if (r_state == fise_pkg::B_ENC) begin
                r_last    <= r_pos + TW'(r_weak);
                r_elapsed <= r_elapsed + TW'(r_dur);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_weak <= i_cell.weak_bit;
            r_dur  <= i_cell.duration_ns;
        end
        if (r_state == fise_pkg::B_DIV && div_done) begin
            r_pos <= prod[fise_pkg::FRAC_W +: TW];
        end
        if (r_state == fise_pkg::B_ENC) begin
            r_sh  <= seq;
            r_cnt <= code_len + 3'(r_weak);
        end else if (out_load) begin
            r_sh  <= {r_sh[31:0], 8'd0};
            r_cnt <= r_cnt - 3'd1;
        end
        if (out_load) begin
            r_out.code_byte <= r_sh[39:32];
            r_out.last_byte <= r_cnt == 3'd1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* tb/tb_top.sv */
module tb_top;
    import fise_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the block's registers and timing state
    logic [TICK_W-1:0]  cfg_tick = TICK_PERIOD_RESET;
    logic [SCALE_W-1:0] cfg_scale = SPEED_SCALE_RESET;
    logic [TIME_W-1:0]  sim_elapsed_ns = '0;
    logic [TIME_W-1:0]  sim_last_pos = '0;

    t_out_item pending_bytes[$];
    int        fail_count = 0;
    bit        gaps_enabled = 1'b1;
    int        hold_left = 0;
    int        stall_burst = 0;

    flux_interval_stream_encoder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #(12 * 400000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_in_item make_cell(input logic start, input logic data,
                                           input logic weak_flag,
                                           input logic [RATE_W-1:0] rate);
        t_in_item c;
        c.track_start  = start;
        c.data_bit     = data;
        c.weak_bit     = weak_flag;
        c.cell_bitrate = rate;
        return c;
    endfunction

    function automatic logic [RATE_W-1:0] pick_bitrate();
        int base;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return RATE_W'($urandom_range(1, 1000));
            2: return RATE_W'($urandom);
            default: begin
                case ($urandom_range(0, 3))
                    0: base = 250000;
                    1: base = 300000;
                    2: base = 500000;
                    default: base = 1000000;
                endcase
                // up to one percent of jitter either side of the nominal floppy rate
                return RATE_W'(base + int'($urandom_range(0, base / 50)) - base / 100);
            end
        endcase
    endfunction

    task automatic predict_cell_bytes(input t_in_item c);
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] ticks;
        logic [TIME_W-1:0] pos;
        logic [TIME_W-1:0] delta;
        logic [63:0]       scaled;
        logic [7:0]        bytes_q[$];
        t_out_item         beat;
        if (c.track_start) begin
            sim_elapsed_ns = '0;
            sim_last_pos   = '0;
        end
        if (c.data_bit || c.weak_bit) begin
            period = (cfg_tick == '0) ? 32'd1 : 32'(cfg_tick);
            ticks  = sim_elapsed_ns / period;
            scaled = 64'(ticks) * 64'(cfg_scale);
            pos    = scaled[FRAC_W+TIME_W-1:FRAC_W];
            delta  = pos - sim_last_pos;
            if (delta < ONE_BYTE_LIMIT) begin
                bytes_q.push_back(delta[7:0]);
            end else if (delta < TWO_BYTE_LIMIT) begin
                bytes_q.push_back(PREFIX_TWO | delta[15:8]);
                bytes_q.push_back(delta[7:0]);
            end else if (delta < THREE_BYTE_LIMIT) begin
                bytes_q.push_back(PREFIX_THREE | delta[23:16]);
                bytes_q.push_back(delta[15:8]);
                bytes_q.push_back(delta[7:0]);
            end else if (delta < FOUR_BYTE_LIMIT) begin
                bytes_q.push_back(PREFIX_FOUR | delta[31:24]);
                bytes_q.push_back(delta[23:16]);
                bytes_q.push_back(delta[15:8]);
                bytes_q.push_back(delta[7:0]);
            end else begin
                bytes_q.push_back(SATURATED_HEAD);
                repeat (3) bytes_q.push_back(FILL_BYTE);
            end
            if (c.weak_bit) begin
                pos = pos + 32'd1;
                bytes_q.push_back(WEAK_BYTE);
            end
            sim_last_pos = pos;
            foreach (bytes_q[i]) begin
                beat.code_byte = bytes_q[i];
                beat.last_byte = (i == bytes_q.size() - 1);
                pending_bytes.push_back(beat);
            end
        end
        if (c.cell_bitrate != '0)
            sim_elapsed_ns += 32'(NS_PER_SECOND) / (32'(c.cell_bitrate) * 32'd2);
    endtask

    // valid stays high after a beat so back-to-back cells need no extra assignment
    task automatic send_cell(input t_in_item c);
        int gap;
        gap = 0;
        if (gaps_enabled && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_cell_bytes(c);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        // quiet cells may still be in the front divider or the queue
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_TICK_PERIOD)
            cfg_tick = value[TICK_W-1:0];
        else
            cfg_scale = value[SCALE_W-1:0];
    endtask

    task automatic run_random_cells(input int count);
        repeat (count) begin
            send_cell(make_cell($urandom_range(0, 19) == 0, 1'($urandom_range(0, 1)),
                                $urandom_range(0, 7) == 0, pick_bitrate()));
        end
    endtask

    task automatic test_directed_cells();
        send_cell(make_cell(1'b1, 1'b1, 1'b0, 24'd250000));
        send_cell(make_cell(1'b0, 1'b1, 1'b0, 24'd250000));
        send_cell(make_cell(1'b0, 1'b0, 1'b0, 24'd250000));
        send_cell(make_cell(1'b0, 1'b0, 1'b1, 24'd250000));
        send_cell(make_cell(1'b0, 1'b1, 1'b1, 24'd0));
        // same time as the weak pulse, so the position goes backward
        send_cell(make_cell(1'b0, 1'b1, 1'b0, 24'd0));
        send_cell(make_cell(1'b0, 1'b0, 1'b0, 24'd1000));
        send_cell(make_cell(1'b0, 1'b1, 1'b0, 24'd10));
        send_cell(make_cell(1'b0, 1'b1, 1'b0, 24'd1));
        send_cell(make_cell(1'b0, 1'b1, 1'b0, 24'd1));
        // wrap elapsed time past 2^32 ns
        repeat (7) send_cell(make_cell(1'b0, 1'b0, 1'b0, 24'd1));
        send_cell(make_cell(1'b0, 1'b1, 1'b0, 24'hFF_FFFF));
        send_cell(make_cell(1'b1, 1'b1, 1'b0, 24'hFF_FFFF));
        send_cell(make_cell(1'b1, 1'b0, 1'b0, 24'hFF_FFFF));
        send_cell(make_cell(1'b0, 1'b1, 1'b1, 24'hFF_FFFF));
    endtask

    task automatic test_backpressure();
        hold_left = 500;
        repeat (12) send_cell(make_cell(1'b0, 1'b1, 1'($urandom_range(0, 1)), 24'd500000));
    endtask

    task automatic test_zero_tick_period();
        wait_idle();
        write_reg(REG_TICK_PERIOD, 32'd0);
        send_cell(make_cell(1'b1, 1'b1, 1'b0, 24'd1));
        send_cell(make_cell(1'b0, 1'b1, 1'b0, 24'd500000));
        send_cell(make_cell(1'b0, 1'b1, 1'b0, 24'd0));
        run_random_cells(20);
    endtask

    task automatic test_scale_extremes();
        wait_idle();
        write_reg(REG_TICK_PERIOD, 32'd1);
        write_reg(REG_SPEED_SCALE, 32'd0);
        send_cell(make_cell(1'b1, 1'b1, 1'b0, 24'd1000));
        send_cell(make_cell(1'b0, 1'b1, 1'b1, 24'd1000));
        run_random_cells(8);
        wait_idle();
        write_reg(REG_SPEED_SCALE, 32'd262143);
        send_cell(make_cell(1'b1, 1'b1, 1'b0, 24'd1));
        // scaled position runs past 2^32
        repeat (4) send_cell(make_cell(1'b0, 1'b1, 1'b0, 24'd1));
        wait_idle();
        write_reg(REG_TICK_PERIOD, 32'd1023);
        run_random_cells(10);
    endtask

    task automatic test_random_settings();
        repeat (3) begin
            wait_idle();
            write_reg(REG_TICK_PERIOD, 32'($urandom_range(0, 1023)));
            write_reg(REG_SPEED_SCALE, 32'($urandom_range(0, 262143)));
            run_random_cells(10);
        end
    endtask

    task automatic test_streaming_no_gaps();
        wait_idle();
        write_reg(REG_TICK_PERIOD, 32'(TICK_PERIOD_RESET));
        write_reg(REG_SPEED_SCALE, 32'(SPEED_SCALE_RESET));
        gaps_enabled = 1'b0;
        send_cell(make_cell(1'b1, 1'b1, 1'b0, 24'd500000));
        run_random_cells(40);
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (!gaps_enabled) begin
            i_out_stall <= 1'b0;
        end else if (stall_burst > 0) begin
            i_out_stall <= 1'b1;
            stall_burst = stall_burst - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_burst = $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_beat
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected beat, actual %h last %0b", $time,
                         o_out_item.code_byte, o_out_item.last_byte);
                fail_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_item.code_byte !== want.code_byte) begin
                    $display("%0t: code_byte expected %h actual %h", $time,
                             want.code_byte, o_out_item.code_byte);
                    fail_count++;
                end
                if (o_out_item.last_byte !== want.last_byte) begin
                    $display("%0t: last_byte expected %0b actual %0b", $time,
                             want.last_byte, o_out_item.last_byte);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cells();
        test_backpressure();
        test_zero_tick_period();
        test_scale_extremes();
        test_random_settings();
        test_streaming_no_gaps();
        wait_idle();
        if (pending_bytes.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, pending_bytes.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
